// ----- sv/wqc_pkg.sv -----
// ----------------------------------------------------------------------------
// wqc_pkg
// Shared types and constants of the weighted quote consensus core.
// ----------------------------------------------------------------------------
package wqc_pkg;

	localparam int MID_W    = 34;
	localparam int SPREAD_W = 33;
	localparam int WEIGHT_W = 17;
	localparam int Q16_W    = 17;

	localparam logic [Q16_W-1:0] Q16_ONE  = 17'd65536;
	localparam logic [Q16_W-1:0] Q16_HALF = 17'd32768;

	// one stored quote slot
	typedef struct packed {
		logic [MID_W-1:0]           mid;
		logic                       has_spread;
		logic signed [SPREAD_W-1:0] spread;
		logic [WEIGHT_W-1:0]        weight;
	} slot_t;

	typedef enum logic [1:0] {
		OP_MID,
		OP_SPREAD,
		OP_CONF,
		OP_DMEAN
	} div_op_t;

endpackage

// ----- sv/weighted_quote_consensus_core.sv -----
// ----------------------------------------------------------------------------
// weighted_quote_consensus_core
// Stores quotes per instrument and source and reports the weighted consensus.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one quote transaction per event;
// output channel (out_valid / out_stall) returns one consensus result each.
// A quote is written into the slot memory, then the instrument's slots are
// walked once (per source: read, multiply, accumulate), the consensus mid,
// spread and confidence come from a shared serial divider (one quotient bit
// a cycle over DIVD_W bits, then an unload step), a second walk (per source:
// read, accumulate) gives the divergence and a last division the mean
// divergence.
// An invalid consensus, a zero mid or no counted source in the second walk
// skips the later stages. One item is in work at a time and the next is
// taken the cycle after the result reaches the output register. An
// instrument out of range goes from the write state straight to the final
// state, with no slot written.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// While the receiver stalls, the finished result holds in the output
// register and the next item is still taken; its result waits until the
// register is free.
// ----------------------------------------------------------------------------
module weighted_quote_consensus_core
	import wqc_pkg::*;
#(
	parameter int NUM_INSTRUMENTS = 16,
	parameter int NUM_SOURCES     = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [3:0]           instrument,
	input  logic [2:0]           source_id,
	input  logic                 bid_present,
	input  logic [31:0]          bid_price,
	input  logic                 ask_present,
	input  logic [31:0]          ask_price,
	input  logic                 last_present,
	input  logic [31:0]          last_price,
	input  logic [16:0]          reliability,
	input  logic [16:0]          usefulness,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           out_instrument,
	output logic                 consensus_valid,
	output logic [32:0]          consensus_mid,
	output logic signed [32:0]   consensus_spread,
	output logic [16:0]          confidence,
	output logic [3:0]           source_count,
	output logic [32:0]          divergence_max,
	output logic [32:0]          divergence_mean,
	output logic [2:0]           worst_source
);

	localparam int NSLOTS  = NUM_INSTRUMENTS * NUM_SOURCES;
	localparam int ADDR_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int SIDX_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int CNT_W   = $clog2(NUM_SOURCES + 1);
	localparam int PROD_W  = MID_W + WEIGHT_W;
	localparam int WSUM_W  = PROD_W + CNT_W;
	localparam int WTS_W   = WEIGHT_W + CNT_W;
	localparam int SSUM_W  = SPREAD_W + CNT_W;
	localparam int DSUM_W  = MID_W + CNT_W;
	localparam int DIVD_W  = WSUM_W;
	localparam int DIVS_W  = WTS_W;
	localparam int DCNT_W  = $clog2(DIVD_W + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR,
		ST_W1_RD,
		ST_W1_MUL,
		ST_W1_ACC,
		ST_CHECK,
		ST_DIV,
		ST_DIV_DONE,
		ST_W2_RD,
		ST_W2_ACC,
		ST_CHECK_D,
		ST_FIN
	} state_t;

	state_t state_q;

	// latched quote
	logic [3:0]  inst_q;
	logic [2:0]  src_q;
	logic        bp_q, ap_q, lp_q;
	logic [31:0] bid_q, ask_q, last_q;
	logic [16:0] rel_q, use_q;

	// slot store
	slot_t             mem [NSLOTS];
	logic [NSLOTS-1:0] used_q;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	slot_t             wdata;
	slot_t             rdata_s1;
	logic              rused_s1;

	// walk state
	logic [ADDR_W-1:0]     base_q;
	logic [SIDX_W-1:0]     cnt_q;
	logic [PROD_W-1:0]     prod_s2;
	logic                  take_s2;
	logic                  hs_s2;
	logic signed [SPREAD_W-1:0] spr_s2;
	logic [WEIGHT_W-1:0]   wt_s2;
	logic [WSUM_W-1:0]     wsum_q;
	logic [WTS_W-1:0]      wts_q;
	logic signed [SSUM_W-1:0] ssum_q;
	logic [CNT_W-1:0]      n_q;
	logic [DSUM_W-1:0]     dsum_q;
	logic [CNT_W-1:0]      dcount_q;
	logic [MID_W-1:0]      dmax_q;
	logic [SIDX_W-1:0]     worst_q;

	// results
	logic                  cvalid_q;
	logic [MID_W-1:0]      cmid_q;
	logic signed [32:0]    cspread_q;
	logic [16:0]           conf_q;
	logic [MID_W-1:0]      dmean_q;

	// serial divider
	div_op_t               div_op_q;
	logic [DIVD_W-1:0]     dvd_q;
	logic [DIVS_W-1:0]     dsr_q;
	logic [DIVS_W:0]       rem_q;
	logic [DCNT_W-1:0]     div_cnt_q;
	logic                  div_neg_q;
	logic [DIVS_W:0]       rem_sh;
	logic                  rem_ge;

	// output register
	logic                  out_valid_q;

	// combinational helpers
	logic                  inst_ok, src_ok;
	logic [16:0]           rel_sat, use_sat;
	logic [17:0]           use_bias;
	logic [34:0]           wprod;
	logic [MID_W-1:0]      new_mid;
	logic [MID_W-1:0]      dv;
	logic [SSUM_W-1:0]     ssum_abs;
	logic [32:0]           quo33;

	assign inst_ok  = (32'(inst_q) < NUM_INSTRUMENTS);
	assign src_ok   = (32'(src_q) < NUM_SOURCES);
	assign rel_sat  = (rel_q > Q16_ONE) ? Q16_ONE : rel_q;
	assign use_sat  = (use_q > Q16_ONE) ? Q16_ONE : use_q;
	assign use_bias = {1'b0, use_sat} + {1'b0, Q16_HALF};
	assign wprod    = 35'(rel_sat) * 35'(use_bias);

	always_comb begin
		if (bp_q && ap_q) begin
			new_mid = {2'b0, bid_q} + {2'b0, ask_q};
		end else if (lp_q) begin
			new_mid = {1'b0, last_q, 1'b0};
		end else begin
			new_mid = '0;
		end
	end

	assign we    = (state_q == ST_WR) && inst_ok && src_ok;
	assign waddr = ADDR_W'(32'(inst_q) * NUM_SOURCES + 32'(src_q));
	assign raddr = base_q + ADDR_W'(cnt_q);

	always_comb begin
		wdata.mid        = new_mid;
		wdata.has_spread = bp_q && ap_q;
		wdata.spread     = $signed({1'b0, ask_q}) - $signed({1'b0, bid_q});
		wdata.weight     = wprod[32:16];
	end

	assign dv = (rdata_s1.mid > cmid_q) ? (rdata_s1.mid - cmid_q) : (cmid_q - rdata_s1.mid);

	assign ssum_abs = ssum_q[SSUM_W-1] ? SSUM_W'(-ssum_q) : SSUM_W'(ssum_q);
	assign rem_sh   = {rem_q[DIVS_W-1:0], dvd_q[DIVD_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, dsr_q});
	assign quo33    = dvd_q[32:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			rused_s1    <= 1'b0;
		end else begin
			rused_s1 <= used_q[raddr];
			// the final state reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						inst_q <= instrument;
						src_q  <= source_id;
						bp_q   <= bid_present;
						bid_q  <= bid_price;
						ap_q   <= ask_present;
						ask_q  <= ask_price;
						lp_q   <= last_present;
						last_q <= last_price;
						rel_q  <= reliability;
						use_q  <= usefulness;
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (we) begin
						used_q[waddr] <= 1'b1;
					end
					base_q    <= ADDR_W'(32'(inst_q) * NUM_SOURCES);
					cnt_q     <= '0;
					wsum_q    <= '0;
					wts_q     <= '0;
					ssum_q    <= '0;
					n_q       <= '0;
					dsum_q    <= '0;
					dcount_q  <= '0;
					dmax_q    <= '0;
					worst_q   <= '0;
					cvalid_q  <= 1'b0;
					cmid_q    <= '0;
					cspread_q <= '0;
					conf_q    <= '0;
					dmean_q   <= '0;
					state_q   <= inst_ok ? ST_W1_RD : ST_FIN;
				end
				ST_W1_RD: begin
					state_q <= ST_W1_MUL;
				end
				ST_W1_MUL: begin
					prod_s2 <= PROD_W'(rdata_s1.mid) * PROD_W'(rdata_s1.weight);
					take_s2 <= rused_s1 && (rdata_s1.mid != '0) && (rdata_s1.weight != '0);
					hs_s2   <= rdata_s1.has_spread;
					spr_s2  <= rdata_s1.spread;
					wt_s2   <= rdata_s1.weight;
					state_q <= ST_W1_ACC;
				end
				ST_W1_ACC: begin
					if (take_s2) begin
						wsum_q <= wsum_q + WSUM_W'(prod_s2);
						wts_q  <= wts_q + WTS_W'(wt_s2);
						n_q    <= n_q + CNT_W'(1);
						if (hs_s2) begin
							ssum_q <= ssum_q + SSUM_W'(spr_s2);
						end
					end
					if (cnt_q == SIDX_W'(NUM_SOURCES - 1)) begin
						state_q <= ST_CHECK;
					end else begin
						cnt_q   <= cnt_q + SIDX_W'(1);
						state_q <= ST_W1_RD;
					end
				end
				ST_CHECK: begin
					if ((wts_q != '0) && (n_q != '0)) begin
						cvalid_q  <= 1'b1;
						div_op_q  <= OP_MID;
						dvd_q     <= DIVD_W'(wsum_q);
						dsr_q     <= DIVS_W'(wts_q);
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (rem_ge) begin
						rem_q <= rem_sh - {1'b0, dsr_q};
					end else begin
						rem_q <= rem_sh;
					end
					dvd_q <= {dvd_q[DIVD_W-2:0], rem_ge};
					if (div_cnt_q == DCNT_W'(DIVD_W - 1)) begin
						state_q <= ST_DIV_DONE;
					end else begin
						div_cnt_q <= div_cnt_q + DCNT_W'(1);
					end
				end
				ST_DIV_DONE: begin
					rem_q     <= '0;
					div_cnt_q <= '0;
					unique case (div_op_q)
						OP_MID: begin
							cmid_q    <= dvd_q[MID_W-1:0];
							div_op_q  <= OP_SPREAD;
							div_neg_q <= ssum_q[SSUM_W-1];
							dvd_q     <= DIVD_W'(ssum_abs);
							dsr_q     <= DIVS_W'(n_q);
							state_q   <= ST_DIV;
						end
						OP_SPREAD: begin
							cspread_q <= div_neg_q ? -$signed(quo33) : $signed(quo33);
							div_op_q  <= OP_CONF;
							dvd_q     <= DIVD_W'(wts_q);
							dsr_q     <= DIVS_W'(n_q);
							state_q   <= ST_DIV;
						end
						OP_CONF: begin
							conf_q <= (dvd_q > DIVD_W'(Q16_ONE)) ? Q16_ONE : dvd_q[16:0];
							cnt_q  <= '0;
							state_q <= (cmid_q != '0) ? ST_W2_RD : ST_FIN;
						end
						OP_DMEAN: begin
							dmean_q <= dvd_q[MID_W-1:0];
							state_q <= ST_FIN;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_W2_RD: begin
					state_q <= ST_W2_ACC;
				end
				ST_W2_ACC: begin
					if (rused_s1 && (rdata_s1.mid != '0)) begin
						dsum_q   <= dsum_q + DSUM_W'(dv);
						dcount_q <= dcount_q + CNT_W'(1);
						if (dv > dmax_q) begin
							dmax_q  <= dv;
							worst_q <= cnt_q;
						end
					end
					if (cnt_q == SIDX_W'(NUM_SOURCES - 1)) begin
						state_q <= ST_CHECK_D;
					end else begin
						cnt_q   <= cnt_q + SIDX_W'(1);
						state_q <= ST_W2_RD;
					end
				end
				ST_CHECK_D: begin
					if (dcount_q != '0) begin
						div_op_q  <= OP_DMEAN;
						dvd_q     <= DIVD_W'(dsum_q);
						dsr_q     <= DIVS_W'(dcount_q);
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q      <= 1'b1;
						out_instrument   <= inst_q;
						consensus_valid  <= cvalid_q;
						consensus_mid    <= cmid_q[32:0];
						consensus_spread <= cspread_q;
						confidence       <= conf_q;
						source_count     <= cvalid_q ? 4'(n_q) : 4'd0;
						divergence_max   <= dmax_q[32:0];
						divergence_mean  <= dmean_q[32:0];
						worst_source     <= 3'(worst_q);
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
